// ===== design/rlw_pkg.sv =====
// Package for the render liveness watchdog: widths, default register values,
// event codes, register indexes, policy and escalation codes.
// No dependencies.
package rlw_pkg;

	localparam int TIME_BITS_DEF  = 48;
	localparam int COUNT_BITS_DEF = 8;

	// Fixed field widths.
	localparam int PERIOD_BITS = 32;
	localparam int LIMIT_BITS  = 8;
	localparam int OP_BITS     = 3;
	localparam int CAUSE_BITS  = 3;
	localparam int ESC_BITS    = 2;
	localparam int POLICY_BITS = 2;
	localparam int CFG_IDX_BITS = 3;

	// Event codes.
	localparam logic [OP_BITS-1:0] OP_START     = 3'd0;
	localparam logic [OP_BITS-1:0] OP_TICK      = 3'd1;
	localparam logic [OP_BITS-1:0] OP_LOST      = 3'd2;
	localparam logic [OP_BITS-1:0] OP_FRAME     = 3'd3;
	localparam logic [OP_BITS-1:0] OP_HINT      = 3'd4;
	localparam logic [OP_BITS-1:0] OP_JUDGEABLE = 3'd5;
	localparam logic [OP_BITS-1:0] OP_CONSUME   = 3'd6;
	localparam logic [OP_BITS-1:0] OP_DISABLE   = 3'd7;

	// Register indexes.
	localparam logic [CFG_IDX_BITS-1:0] REG_PROBE_INTERVAL     = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PROBE_INTERVAL = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MISSED_LIMIT       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOSS_WINDOW        = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_WINDOW_LOSSES  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_RECOVERIES     = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_CAP           = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOSS_POLICY        = 3'd7;

	// Register reset values.
	localparam logic [PERIOD_BITS-1:0] PROBE_INTERVAL_RST     = 32'd5000;
	localparam logic [PERIOD_BITS-1:0] MAX_PROBE_INTERVAL_RST = 32'd60000;
	localparam logic [LIMIT_BITS-1:0]  MISSED_LIMIT_RST       = 8'd2;
	localparam logic [PERIOD_BITS-1:0] LOSS_WINDOW_RST        = 32'd600000;
	localparam logic [LIMIT_BITS-1:0]  MAX_WINDOW_LOSSES_RST  = 8'd3;
	localparam logic [LIMIT_BITS-1:0]  MAX_RECOVERIES_RST     = 8'd5;
	localparam logic [PERIOD_BITS-1:0] HOLD_CAP_RST           = 32'd30000;

	// Loss policies.
	localparam logic [POLICY_BITS-1:0] POLICY_RESTART = 2'd0;
	localparam logic [POLICY_BITS-1:0] POLICY_EXIT    = 2'd1;
	localparam logic [POLICY_BITS-1:0] POLICY_LOG     = 2'd2;
	localparam logic [POLICY_BITS-1:0] POLICY_RESTART_ALT = 2'd3;

	// Causes and escalation codes.
	localparam logic [CAUSE_BITS-1:0] CAUSE_NONE      = 3'd0;
	localparam logic [CAUSE_BITS-1:0] CAUSE_NO_FRAMES = 3'd1;
	localparam logic [ESC_BITS-1:0]   ESC_NONE        = 2'd0;
	localparam logic [ESC_BITS-1:0]   ESC_THRASH      = 2'd1;
	localparam logic [ESC_BITS-1:0]   ESC_EXHAUSTED   = 2'd2;

endpackage

// ===== design/rlw_backoff.sv =====
// Restart backoff: min(interval << (attempts-1), ceiling) without overflow.
// Depends on rlw_pkg.
module rlw_backoff #(
	parameter int COUNT_BITS = rlw_pkg::COUNT_BITS_DEF
) (
	input  logic [rlw_pkg::PERIOD_BITS-1:0] interval,
	input  logic [rlw_pkg::PERIOD_BITS-1:0] ceiling,
	input  logic [COUNT_BITS-1:0]           attempts,
	output logic [rlw_pkg::PERIOD_BITS-1:0] period
);

	localparam int PB = rlw_pkg::PERIOD_BITS;

	logic [31:0]     shift_w;
	logic [2*PB-1:0] wide;

	assign shift_w = 32'(attempts) - 32'd1;
	assign wide    = {{PB{1'b0}}, interval} << shift_w[4:0];

	always_comb begin
		if (32'(attempts) <= 32'd1) begin
			period = (interval > ceiling) ? ceiling : interval;
		end else if (interval == '0) begin
			period = '0;
		end else if (shift_w >= 32'd32) begin
			period = ceiling;
		end else if (wide > {{PB{1'b0}}, ceiling}) begin
			period = ceiling;
		end else begin
			period = wide[PB-1:0];
		end
	end

endmodule

// ===== design/render_liveness_watchdog_unit.sv =====
// Top level of the render liveness watchdog: input register, event logic,
// watchdog state, configuration registers and result register.
// Depends on rlw_pkg and rlw_backoff.
//
//  channel   signals                                       direction
//  in        in_valid, in_ready, op, now_ms, lost_cause,    request in
//            judgeable
//  out       out_valid, out_ready, probe_kick ... hold_active   result out
//  cfg       cfg_write, cfg_index, cfg_data                 register write
//
// One event per cycle unless a waiting result stalls: a request is registered,
// then evaluated against the watchdog state while the result register loads,
// which raises out_valid. A waiting result holds the evaluation stage; the
// input register can still take one request if it is empty, then in_ready
// stays low until out_ready is seen.
// Reset clears the valid flags and the watchdog state and loads the register defaults.
module render_liveness_watchdog_unit #(
	parameter int TIME_BITS  = rlw_pkg::TIME_BITS_DEF,
	parameter int COUNT_BITS = rlw_pkg::COUNT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [rlw_pkg::OP_BITS-1:0]      op,
	input  logic [TIME_BITS-1:0]             now_ms,
	input  logic [rlw_pkg::CAUSE_BITS-1:0]   lost_cause,
	input  logic                             judgeable,

	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             probe_kick,
	output logic [rlw_pkg::PERIOD_BITS-1:0]  timer_period,
	output logic                             loss_notice,
	output logic [rlw_pkg::CAUSE_BITS-1:0]   loss_cause,
	output logic [rlw_pkg::ESC_BITS-1:0]     escalation,
	output logic                             quit_process,
	output logic                             rebuild_engine,
	output logic                             hold_expired_taken,
	output logic                             hold_active,

	input  logic                             cfg_write,
	input  logic [rlw_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [rlw_pkg::PERIOD_BITS-1:0]  cfg_data
);

	localparam int PB   = rlw_pkg::PERIOD_BITS;
	localparam int LB   = rlw_pkg::LIMIT_BITS;
	localparam int CMPW = (COUNT_BITS > LB) ? COUNT_BITS : LB;

	// Configuration registers.
	logic [PB-1:0] probe_interval_q, max_probe_interval_q, loss_window_q, hold_cap_q;
	logic [LB-1:0] missed_limit_q, max_window_losses_q, max_recoveries_q;
	logic [rlw_pkg::POLICY_BITS-1:0] loss_policy_q;

	// Input stage.
	logic                           valid_s1;
	logic [rlw_pkg::OP_BITS-1:0]    op_s1;
	logic [TIME_BITS-1:0]           now_s1;
	logic [rlw_pkg::CAUSE_BITS-1:0] cause_s1;
	logic                           judge_s1;

	// Watchdog state.
	logic disabled_q, probe_pending_q, loss_reported_q, window_open_q;
	logic holding_q, hold_expired_q;
	logic [COUNT_BITS-1:0] missed_count_q, window_losses_q, recovery_count_q;
	logic [TIME_BITS-1:0]  window_start_q, hold_start_q;

	// Result register.
	logic                           out_valid_q;
	logic                           probe_kick_q, loss_notice_q, exit_q, restart_q;
	logic                           taken_q, hold_active_q;
	logic [PB-1:0]                  timer_period_q;
	logic [rlw_pkg::CAUSE_BITS-1:0] loss_cause_q;
	logic [rlw_pkg::ESC_BITS-1:0]   escalation_q;

	logic advance;
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	function automatic logic hold_force(input logic h, input logic [TIME_BITS-1:0] start,
		input logic [TIME_BITS-1:0] now, input logic [PB-1:0] cap);
		logic [TIME_BITS-1:0] el;
		el = now - start;
		if (!h) begin
			hold_force = 1'b0;
		end else if (cap == '0) begin
			hold_force = 1'b1;
		end else begin
			hold_force = el < TIME_BITS'(cap);
		end
	endfunction

	// Backoff sees the recovery count after the increment of a restart.
	logic [COUNT_BITS-1:0] rc_inc;
	logic [PB-1:0]         backoff_period;
	assign rc_inc = sat_inc(recovery_count_q);

	rlw_backoff #(
		.COUNT_BITS(COUNT_BITS)
	) u_backoff (
		.interval (probe_interval_q),
		.ceiling  (max_probe_interval_q),
		.attempts (rc_inc),
		.period   (backoff_period)
	);

	// Next-state and result logic.
	logic n_dis, n_pp, n_lr, n_wo, n_hold, n_hexp;
	logic [COUNT_BITS-1:0] n_mc, n_wl, n_rc;
	logic [TIME_BITS-1:0]  n_ws, n_hs;
	logic                           r_start, r_report, r_exit, r_restart, r_taken, r_active;
	logic [PB-1:0]                  r_period;
	logic [rlw_pkg::CAUSE_BITS-1:0] r_cause;
	logic [rlw_pkg::ESC_BITS-1:0]   r_esc;

	always_comb begin
		logic                           do_loss;
		logic [rlw_pkg::CAUSE_BITS-1:0] cause_v;
		logic [TIME_BITS-1:0]           win_el;
		logic                           thrash, exhausted, restart_pol;

		n_dis = disabled_q;     n_pp = probe_pending_q; n_lr = loss_reported_q;
		n_wo = window_open_q;   n_hold = holding_q;     n_hexp = hold_expired_q;
		n_mc = missed_count_q;  n_wl = window_losses_q; n_rc = recovery_count_q;
		n_ws = window_start_q;  n_hs = hold_start_q;
		r_start = 1'b0; r_report = 1'b0; r_exit = 1'b0; r_restart = 1'b0;
		r_taken = 1'b0; r_period = '0; r_cause = rlw_pkg::CAUSE_NONE;
		r_esc = rlw_pkg::ESC_NONE;
		do_loss = 1'b0;
		cause_v = rlw_pkg::CAUSE_NONE;
		thrash = 1'b0;
		exhausted = 1'b0;
		restart_pol = 1'b0;
		win_el = now_s1 - window_start_q;

		case (op_s1)
			rlw_pkg::OP_START: begin
				if (!disabled_q) begin
					n_pp = 1'b1;
					r_start = 1'b1;
					r_period = probe_interval_q;
				end
			end
			rlw_pkg::OP_TICK: begin
				if (!disabled_q) begin
					if (hold_force(holding_q, hold_start_q, now_s1, hold_cap_q)) begin
						n_pp = 1'b1;
						r_start = 1'b1;
					end else begin
						if (holding_q) begin
							n_hexp = 1'b1;
						end
						if (probe_pending_q) begin
							n_mc = sat_inc(missed_count_q);
						end
						if (probe_pending_q && CMPW'(n_mc) >= CMPW'(missed_limit_q)) begin
							do_loss = 1'b1;
							cause_v = rlw_pkg::CAUSE_NO_FRAMES;
						end else begin
							n_pp = 1'b1;
							r_start = 1'b1;
						end
					end
				end
			end
			rlw_pkg::OP_LOST: begin
				if (!disabled_q) begin
					do_loss = 1'b1;
					cause_v = cause_s1;
				end
			end
			rlw_pkg::OP_FRAME: begin
				if (!disabled_q) begin
					n_pp = 1'b0;
					n_mc = '0;
					n_lr = 1'b0;
					n_hold = 1'b0;
					n_hs = '0;
					n_hexp = 1'b0;
					if (recovery_count_q != '0) begin
						n_rc = '0;
						r_period = probe_interval_q;
					end
				end
			end
			rlw_pkg::OP_HINT: begin
				if (!disabled_q) begin
					n_pp = 1'b1;
					r_start = 1'b1;
				end
			end
			rlw_pkg::OP_JUDGEABLE: begin
				if (judge_s1) begin
					n_hold = 1'b0;
					n_hs = '0;
					n_hexp = 1'b0;
				end else if (!holding_q) begin
					n_hold = 1'b1;
					n_hs = now_s1;
					n_hexp = 1'b0;
				end
			end
			rlw_pkg::OP_CONSUME: begin
				if (hold_expired_q) begin
					n_hold = 1'b0;
					n_hs = '0;
					n_hexp = 1'b0;
					r_taken = 1'b1;
				end
			end
			default: begin
				n_dis = 1'b1;
				n_pp = 1'b0;
			end
		endcase

		// Loss declaration: the window is counted once per episode.
		if (do_loss) begin
			r_cause = cause_v;
			if (!loss_reported_q) begin
				n_lr = 1'b1;
				r_report = 1'b1;
				if (!window_open_q || (loss_window_q != '0 &&
					win_el > TIME_BITS'(loss_window_q))) begin
					n_wo = 1'b1;
					n_ws = now_s1;
					n_wl = COUNT_BITS'(1);
				end else begin
					n_wl = sat_inc(window_losses_q);
				end
			end
			thrash = (max_window_losses_q != '0) &&
				(CMPW'(n_wl) > CMPW'(max_window_losses_q));
			exhausted = (max_recoveries_q != '0) &&
				(CMPW'(recovery_count_q) >= CMPW'(max_recoveries_q));
			restart_pol = (loss_policy_q == rlw_pkg::POLICY_RESTART) ||
				(loss_policy_q == rlw_pkg::POLICY_RESTART_ALT);
			if (restart_pol && (thrash || exhausted)) begin
				r_esc = thrash ? rlw_pkg::ESC_THRASH : rlw_pkg::ESC_EXHAUSTED;
				n_dis = 1'b1;
				r_exit = 1'b1;
			end else if (loss_policy_q == rlw_pkg::POLICY_EXIT) begin
				n_dis = 1'b1;
				r_exit = 1'b1;
			end else if (loss_policy_q == rlw_pkg::POLICY_LOG) begin
				n_pp = 1'b1;
				r_start = 1'b1;
			end else begin
				n_rc = rc_inc;
				n_mc = '0;
				n_pp = 1'b1;
				r_restart = 1'b1;
				r_period = backoff_period;
			end
		end

		r_active = hold_force(n_hold, n_hs, now_s1, hold_cap_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_interval_q     <= rlw_pkg::PROBE_INTERVAL_RST;
			max_probe_interval_q <= rlw_pkg::MAX_PROBE_INTERVAL_RST;
			missed_limit_q       <= rlw_pkg::MISSED_LIMIT_RST;
			loss_window_q        <= rlw_pkg::LOSS_WINDOW_RST;
			max_window_losses_q  <= rlw_pkg::MAX_WINDOW_LOSSES_RST;
			max_recoveries_q     <= rlw_pkg::MAX_RECOVERIES_RST;
			hold_cap_q           <= rlw_pkg::HOLD_CAP_RST;
			loss_policy_q        <= rlw_pkg::POLICY_RESTART;
		end else if (cfg_write) begin
			case (cfg_index)
				rlw_pkg::REG_PROBE_INTERVAL:     probe_interval_q     <= cfg_data;
				rlw_pkg::REG_MAX_PROBE_INTERVAL: max_probe_interval_q <= cfg_data;
				rlw_pkg::REG_MISSED_LIMIT:       missed_limit_q       <= cfg_data[LB-1:0];
				rlw_pkg::REG_LOSS_WINDOW:        loss_window_q        <= cfg_data;
				rlw_pkg::REG_MAX_WINDOW_LOSSES:  max_window_losses_q  <= cfg_data[LB-1:0];
				rlw_pkg::REG_MAX_RECOVERIES:     max_recoveries_q     <= cfg_data[LB-1:0];
				rlw_pkg::REG_HOLD_CAP:           hold_cap_q           <= cfg_data;
				rlw_pkg::REG_LOSS_POLICY:
					loss_policy_q <= cfg_data[rlw_pkg::POLICY_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage control and payload.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= op;
			now_s1   <= now_ms;
			cause_s1 <= lost_cause;
			judge_s1 <= judgeable;
		end
	end

	// Watchdog state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disabled_q       <= 1'b0;
			probe_pending_q  <= 1'b0;
			loss_reported_q  <= 1'b0;
			window_open_q    <= 1'b0;
			holding_q        <= 1'b0;
			hold_expired_q   <= 1'b0;
			missed_count_q   <= '0;
			window_losses_q  <= '0;
			recovery_count_q <= '0;
			window_start_q   <= '0;
			hold_start_q     <= '0;
		end else if (advance) begin
			disabled_q       <= n_dis;
			probe_pending_q  <= n_pp;
			loss_reported_q  <= n_lr;
			window_open_q    <= n_wo;
			holding_q        <= n_hold;
			hold_expired_q   <= n_hexp;
			missed_count_q   <= n_mc;
			window_losses_q  <= n_wl;
			recovery_count_q <= n_rc;
			window_start_q   <= n_ws;
			hold_start_q     <= n_hs;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			probe_kick_q   <= r_start;
			timer_period_q <= r_period;
			loss_notice_q  <= r_report;
			loss_cause_q   <= r_cause;
			escalation_q   <= r_esc;
			exit_q         <= r_exit;
			restart_q      <= r_restart;
			taken_q        <= r_taken;
			hold_active_q  <= r_active;
		end
	end

	assign out_valid          = out_valid_q;
	assign probe_kick         = probe_kick_q;
	assign timer_period       = timer_period_q;
	assign loss_notice        = loss_notice_q;
	assign loss_cause         = loss_cause_q;
	assign escalation         = escalation_q;
	assign quit_process       = exit_q;
	assign rebuild_engine     = restart_q;
	assign hold_expired_taken = taken_q;
	assign hold_active        = hold_active_q;

endmodule
